FILE: src/apoc_pkg.sv
// ----------------------------------------------------------------------------
// apoc_pkg
// Shared types, widths and the overlap test for the box pair overlap counter.
// ----------------------------------------------------------------------------
package apoc_pkg;

    localparam int COORD_W = 32;
    localparam int PAIR_W  = 15;
    localparam int COUNT_W = 9;

    localparam logic [PAIR_W-1:0]  PAIR_MAX  = 15'h7fff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1ff;

    // one box as six signed q16.16 bounds
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    // control flags that travel with a box down the chain
    typedef struct packed {
        logic               valid;   // slot holds a box
        logic               drop;    // store was full, box takes no part
        logic               placed;  // box already settled into a cell
        logic               last;    // final box of the set
        logic               ovf;     // set overflow, valid with last
        logic [COUNT_W-1:0] boxes;   // boxes in the set, valid with last
    } tok_t;

    // inclusive overlap on all three axes
    function automatic logic boxes_overlap(input box_t a, input box_t b);
        logic ox;
        logic oy;
        logic oz;
        ox = (a.max_x >= b.min_x) && (b.max_x >= a.min_x);
        oy = (a.max_y >= b.min_y) && (b.max_y >= a.min_y);
        oz = (a.max_z >= b.min_z) && (b.max_z >= a.min_z);
        return ox && oy && oz;
    endfunction

endpackage

FILE: src/apoc_entry.sv
// ----------------------------------------------------------------------------
// apoc_entry
// Counts boxes of the current set, flags boxes past capacity and launches
// each accepted beat into the head of the cell chain.
// ----------------------------------------------------------------------------
module apoc_entry #(
    parameter int MAX_BOXES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  apoc_pkg::box_t  box_in,
    input  logic            last_in,
    output apoc_pkg::tok_t  tok_out,
    output apoc_pkg::box_t  box_out
);
    import apoc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    box_t             box_reg;

    logic             full;
    logic [CNT_W-1:0] stored_after;
    logic [31:0]      after_ext;
    logic             ovf_after;

    // fill state of the current set
    always_comb
    begin
        full         = (count_reg == CNT_W'(MAX_BOXES));
        stored_after = full ? count_reg : count_reg + CNT_W'(1);
        after_ext    = 32'(stored_after);
        ovf_after    = ovf_reg | full;

        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            count_next = last_in ? '0 : stored_after;
            ovf_next   = last_in ? 1'b0 : ovf_after;
        end

        tok_next        = '0;
        tok_next.valid  = accept;
        tok_next.drop   = full;
        tok_next.placed = 1'b0;
        tok_next.last   = last_in;
        tok_next.ovf    = ovf_after;
        tok_next.boxes  = (after_ext > 32'(COUNT_MAX)) ? COUNT_MAX : after_ext[COUNT_W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            tok_reg   <= tok_next;
        end
    end

    // box payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_reg <= box_in;
        end
    end

    assign tok_out = tok_reg;
    assign box_out = box_reg;

endmodule

FILE: src/apoc_cell.sv
// ----------------------------------------------------------------------------
// apoc_cell
// One stage of the chain: holds one stored box, tests each passing box
// against it, and takes in a passing box not yet placed when the cell is empty.
// ----------------------------------------------------------------------------
module apoc_cell #(
    parameter int HIT_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  apoc_pkg::tok_t   tok_in,
    input  apoc_pkg::box_t   box_in,
    input  logic [HIT_W-1:0] hits_in,
    output apoc_pkg::tok_t   tok_out,
    output apoc_pkg::box_t   box_out,
    output logic [HIT_W-1:0] hits_out
);
    import apoc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    box_t             stored_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    box_t             box_reg;
    logic [HIT_W-1:0] hits_reg;
    logic [HIT_W-1:0] hits_next;

    logic live;
    logic hit;
    logic store;

    // compare against the held box or settle into this cell
    always_comb
    begin
        live  = tok_in.valid && !tok_in.drop;
        hit   = live && valid_reg && boxes_overlap(stored_reg, box_in);
        store = live && !valid_reg && !tok_in.placed;

        valid_next = valid_reg | store;
        // the final box of a set empties the cell behind it
        if (tok_in.valid && tok_in.last)
        begin
            valid_next = 1'b0;
        end

        tok_next        = tok_in;
        tok_next.placed = tok_in.placed | store;
        hits_next       = hits_in + HIT_W'(hit);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            stored_reg <= box_in;
        end
        box_reg  <= box_in;
        hits_reg <= hits_next;
    end

    assign tok_out  = tok_reg;
    assign box_out  = box_reg;
    assign hits_out = hits_reg;

endmodule

FILE: src/apoc_exit.sv
// ----------------------------------------------------------------------------
// apoc_exit
// Adds each box's hit count into the saturating pair total as it leaves the
// chain and posts the result beat when the final box of a set comes out.
// ----------------------------------------------------------------------------
module apoc_exit #(
    parameter int HIT_W = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  apoc_pkg::tok_t                 tok_in,
    input  logic [HIT_W-1:0]               hits_in,
    output logic                           done,
    output logic [apoc_pkg::PAIR_W-1:0]    pair_count,
    output logic [apoc_pkg::COUNT_W-1:0]   boxes_counted,
    output logic                           overflow
);
    import apoc_pkg::*;

    localparam int SUM_W = ((HIT_W > PAIR_W) ? HIT_W : PAIR_W) + 1;

    logic [PAIR_W-1:0]  total_reg;
    logic [PAIR_W-1:0]  total_next;
    logic               done_reg;
    logic               done_next;
    logic [PAIR_W-1:0]  pair_reg;
    logic [COUNT_W-1:0] boxes_reg;
    logic               ovf_reg;

    logic [SUM_W-1:0]   sum;
    logic [PAIR_W-1:0]  sat;

    // saturating accumulate
    always_comb
    begin
        sum = SUM_W'(total_reg) + SUM_W'(hits_in);
        sat = (sum > SUM_W'(PAIR_MAX)) ? PAIR_MAX : sum[PAIR_W-1:0];

        total_next = total_reg;
        done_next  = 1'b0;
        if (tok_in.valid)
        begin
            total_next = tok_in.last ? '0 : sat;
            done_next  = tok_in.last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            pair_reg  <= sat;
            boxes_reg <= tok_in.boxes;
            ovf_reg   <= tok_in.ovf;
        end
    end

    assign done          = done_reg;
    assign pair_count    = pair_reg;
    assign boxes_counted = boxes_reg;
    assign overflow      = ovf_reg;

endmodule

FILE: src/aabb_pair_overlap_counter_top.sv
// ----------------------------------------------------------------------------
// aabb_pair_overlap_counter_top
// Counts overlapping pairs among a set of 3D boxes with a chain of cells,
// one stored box per cell; each new box walks the chain and, unless it was
// dropped past capacity, is tested against every stored box on its way.
// ----------------------------------------------------------------------------
// throughput: one box per cycle, busy stays low; every beat walks the chain
// path: done rises once the last box has passed the entry register, which loads
//   at the accepting edge, then one register per cell, then the result register
// the receiver cannot stall: the result beat lasts exactly one cycle
// reset: asynchronous, clears counts, cell valid bits and in-flight beats
// ----------------------------------------------------------------------------
module aabb_pair_overlap_counter_top #(
    parameter int MAX_BOXES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            min_x,
    input  logic signed [31:0]            min_y,
    input  logic signed [31:0]            min_z,
    input  logic signed [31:0]            max_x,
    input  logic signed [31:0]            max_y,
    input  logic signed [31:0]            max_z,
    input  logic                          last_box,
    output logic                          done,
    output logic [apoc_pkg::PAIR_W-1:0]   pair_count,
    output logic [apoc_pkg::COUNT_W-1:0]  boxes_counted,
    output logic                          overflow
);
    import apoc_pkg::*;

    localparam int HIT_W = $clog2(MAX_BOXES + 1);

    box_t             box_in;
    logic             accept;
    tok_t             tok_chain  [MAX_BOXES+1];
    box_t             box_chain  [MAX_BOXES+1];
    logic [HIT_W-1:0] hits_chain [MAX_BOXES+1];

    // chain takes a beat every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // pack the input beat
    always_comb
    begin
        box_in.min_x = min_x;
        box_in.min_y = min_y;
        box_in.min_z = min_z;
        box_in.max_x = max_x;
        box_in.max_y = max_y;
        box_in.max_z = max_z;
    end

    // head of the chain
    apoc_entry #(
        .MAX_BOXES(MAX_BOXES)
    ) u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .box_in  (box_in),
        .last_in (last_box),
        .tok_out (tok_chain[0]),
        .box_out (box_chain[0])
    );

    assign hits_chain[0] = '0;

    // row of cells
    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        apoc_cell #(
            .HIT_W(HIT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok_chain[i]),
            .box_in   (box_chain[i]),
            .hits_in  (hits_chain[i]),
            .tok_out  (tok_chain[i+1]),
            .box_out  (box_chain[i+1]),
            .hits_out (hits_chain[i+1])
        );
    end

    // tail of the chain
    apoc_exit #(
        .HIT_W(HIT_W)
    ) u_exit (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_in        (tok_chain[MAX_BOXES]),
        .hits_in       (hits_chain[MAX_BOXES]),
        .done          (done),
        .pair_count    (pair_count),
        .boxes_counted (boxes_counted),
        .overflow      (overflow)
    );

endmodule
